### hdl/rtsf_pkg.sv
// shared types, constants and register codes for the resistive touch sample filter
package rtsf_pkg;

    // field widths
    localparam int SAMPLE_BITS = 12;
    localparam int PRESS_BITS  = SAMPLE_BITS + 1;
    localparam int TIME_BITS   = 32;
    localparam int IVAL_BITS   = 8;
    localparam int ROT_BITS    = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = PRESS_BITS;

    localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = {SAMPLE_BITS{1'b1}};

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] REG_PRESSURE_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] REG_MIN_INTERVAL_MS    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] REG_ROTATION_MODE      = 2'd2;

    // screen rotation codes
    typedef enum logic [ROT_BITS-1:0] {
        ROT_QUARTER      = 2'd0,  // x' = max - y, y' = x
        ROT_NONE         = 2'd1,  // x' = x, y' = y
        ROT_THREE_QUARTER = 2'd2, // x' = y, y' = max - x
        ROT_HALF         = 2'd3   // x' = max - x, y' = max - y
    } rot_t;

    // reset values
    localparam logic [PRESS_BITS-1:0] THRESHOLD_RESET = 13'd200;
    localparam logic [IVAL_BITS-1:0]  INTERVAL_RESET  = 8'd3;
    localparam rot_t                  ROTATION_RESET  = ROT_NONE;
    localparam logic [TIME_BITS-1:0]  LAST_GOOD_RESET = 32'h8000_0000;

    typedef struct packed {
        logic [PRESS_BITS-1:0] pressure_threshold;
        logic [IVAL_BITS-1:0]  min_interval_ms;
        rot_t                  rotation_mode;
    } cfg_t;

    typedef struct packed {
        logic [TIME_BITS-1:0]   now_ms;
        logic [SAMPLE_BITS-1:0] pressure_one;
        logic [SAMPLE_BITS-1:0] pressure_two;
        logic [SAMPLE_BITS-1:0] x_first;
        logic [SAMPLE_BITS-1:0] x_second;
        logic [SAMPLE_BITS-1:0] x_third;
        logic [SAMPLE_BITS-1:0] y_first;
        logic [SAMPLE_BITS-1:0] y_second;
        logic [SAMPLE_BITS-1:0] y_third;
    } sample_t;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] pos_x;
        logic [SAMPLE_BITS-1:0] pos_y;
        logic [PRESS_BITS-1:0]  pressure;
        logic                   touched;
    } result_t;

endpackage

### hdl/resistive_touch_sample_filter_unit.sv
// top level: config registers, input register, filter core and result register
//
//  channel   signals                                    direction
//  -------   ----------------------------------------   ---------
//  sample    sample_valid, sample_ready, sample          in
//  result    result_valid, result_ready, result          out
//  cfg       cfg_valid, cfg_ready, cfg_index, cfg_data   in
//
// An item waits in the input register, where the filter core processes it
// and updates the held state, then moves to the result register when that
// register is free or being read; result_valid rises once the item is in the
// result register. One item per cycle is sustained while result_ready stays
// high. A stalled result holds the input register, and sample_ready drops
// only when both registers are full.
// Reset restores the register defaults and resets the held state; cfg_ready
// is always high.
module resistive_touch_sample_filter_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                sample_valid,
    output logic                                sample_ready,
    input  rtsf_pkg::sample_t                   sample,
    output logic                                result_valid,
    input  logic                                result_ready,
    output rtsf_pkg::result_t                   result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [rtsf_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [rtsf_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import rtsf_pkg::*;

    cfg_t    cfg_reg;
    logic    item_valid_reg;
    sample_t item_reg;
    logic    out_valid_reg;
    result_t out_reg;
    result_t core_result;
    logic    advance;
    logic    step;

    // pipeline flow
    assign advance      = !out_valid_reg || result_ready;
    assign step         = item_valid_reg && advance;
    assign sample_ready = !item_valid_reg || advance;
    assign cfg_ready    = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pressure_threshold <= THRESHOLD_RESET;
            cfg_reg.min_interval_ms    <= INTERVAL_RESET;
            cfg_reg.rotation_mode      <= ROTATION_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_PRESSURE_THRESHOLD: cfg_reg.pressure_threshold <= cfg_data;
                REG_MIN_INTERVAL_MS:    cfg_reg.min_interval_ms    <= cfg_data[IVAL_BITS-1:0];
                REG_ROTATION_MODE:      cfg_reg.rotation_mode      <= rot_t'(cfg_data[ROT_BITS-1:0]);
                default:                ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (sample_ready)
        begin
            item_valid_reg <= sample_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && sample_ready)
        begin
            item_reg <= sample;
        end
    end

    rtsf_filter_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (core_result)
    );

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= item_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step)
        begin
            out_reg <= core_result;
        end
    end

    assign result_valid = out_valid_reg;
    assign result       = out_reg;

endmodule

### hdl/rtsf_pair_mean.sv
// mean of the closest two of three samples on one axis
module rtsf_pair_mean (
    input  logic [rtsf_pkg::SAMPLE_BITS-1:0] a,
    input  logic [rtsf_pkg::SAMPLE_BITS-1:0] b,
    input  logic [rtsf_pkg::SAMPLE_BITS-1:0] c,
    output logic [rtsf_pkg::SAMPLE_BITS-1:0] mean
);
    import rtsf_pkg::*;

    logic [SAMPLE_BITS-1:0] d_ab;
    logic [SAMPLE_BITS-1:0] d_ac;
    logic [SAMPLE_BITS-1:0] d_bc;
    logic [SAMPLE_BITS-1:0] p;
    logic [SAMPLE_BITS-1:0] q;
    logic [SAMPLE_BITS:0]   sum;

    // pairwise distances
    assign d_ab = (a > b) ? a - b : b - a;
    assign d_ac = (a > c) ? a - c : c - a;
    assign d_bc = (b > c) ? b - c : c - b;

    // pick the pair, ties go to first/second, then first/third
    always_comb
    begin
        if (d_ab <= d_ac && d_ab <= d_bc)
        begin
            p = a;
            q = b;
        end
        else if (d_ac <= d_bc)
        begin
            p = a;
            q = c;
        end
        else
        begin
            p = b;
            q = c;
        end
    end

    // mean rounded down
    assign sum  = {1'b0, p} + {1'b0, q};
    assign mean = sum[SAMPLE_BITS:1];

endmodule

### hdl/rtsf_filter_core.sv
// held touch state and the per-item update: interval gate, pressure, averaging, rotation
module rtsf_filter_core (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  rtsf_pkg::sample_t item,
    input  rtsf_pkg::cfg_t    cfg,
    output rtsf_pkg::result_t result
);
    import rtsf_pkg::*;

    logic [TIME_BITS-1:0]   last_good_reg;
    logic [TIME_BITS-1:0]   last_good_next;
    logic [SAMPLE_BITS-1:0] held_x_reg;
    logic [SAMPLE_BITS-1:0] held_x_next;
    logic [SAMPLE_BITS-1:0] held_y_reg;
    logic [SAMPLE_BITS-1:0] held_y_next;
    logic [PRESS_BITS-1:0]  held_press_reg;
    logic [PRESS_BITS-1:0]  held_press_next;

    logic [TIME_BITS-1:0]   elapsed;
    logic                   due;
    logic [PRESS_BITS-1:0]  press;
    logic                   good;
    logic [SAMPLE_BITS-1:0] mean_x;
    logic [SAMPLE_BITS-1:0] mean_y;
    logic [SAMPLE_BITS-1:0] rot_x;
    logic [SAMPLE_BITS-1:0] rot_y;

    // interval gate with wrapping difference
    assign elapsed = item.now_ms - last_good_reg;
    assign due     = elapsed >= {{(TIME_BITS-IVAL_BITS){1'b0}}, cfg.min_interval_ms};

    // z1 + (max - z2)
    assign press = {1'b0, item.pressure_one} + {1'b0, ~item.pressure_two};
    assign good  = due && (press >= cfg.pressure_threshold);

    rtsf_pair_mean u_mean_x (
        .a    (item.x_first),
        .b    (item.x_second),
        .c    (item.x_third),
        .mean (mean_x)
    );

    rtsf_pair_mean u_mean_y (
        .a    (item.y_first),
        .b    (item.y_second),
        .c    (item.y_third),
        .mean (mean_y)
    );

    // rotation
    always_comb
    begin
        unique case (cfg.rotation_mode)
            ROT_QUARTER:
            begin
                rot_x = SAMPLE_MAX - mean_y;
                rot_y = mean_x;
            end
            ROT_NONE:
            begin
                rot_x = mean_x;
                rot_y = mean_y;
            end
            ROT_THREE_QUARTER:
            begin
                rot_x = mean_y;
                rot_y = SAMPLE_MAX - mean_x;
            end
            ROT_HALF:
            begin
                rot_x = SAMPLE_MAX - mean_x;
                rot_y = SAMPLE_MAX - mean_y;
            end
            default:
            begin
                rot_x = mean_x;
                rot_y = mean_y;
            end
        endcase
    end

    // next held state for this item
    assign held_press_next = due  ? press       : held_press_reg;
    assign held_x_next     = good ? rot_x       : held_x_reg;
    assign held_y_next     = good ? rot_y       : held_y_reg;
    assign last_good_next  = good ? item.now_ms : last_good_reg;

    // result reflects the state after this item
    assign result.pos_x    = held_x_next;
    assign result.pos_y    = held_y_next;
    assign result.pressure = held_press_next;
    assign result.touched  = held_press_next >= cfg.pressure_threshold;

    // held state, updated once per processed item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_good_reg  <= LAST_GOOD_RESET;
            held_x_reg     <= '0;
            held_y_reg     <= '0;
            held_press_reg <= '0;
        end
        else if (step)
        begin
            last_good_reg  <= last_good_next;
            held_x_reg     <= held_x_next;
            held_y_reg     <= held_y_next;
            held_press_reg <= held_press_next;
        end
    end

endmodule
